// ----- hw/rtl/bitmap_page_allocator_defines.svh -----
// Assertion helpers shared by the allocator modules.
// They expect i_clk and i_rst_n in the scope where they are used.
`ifndef BITMAP_PAGE_ALLOCATOR_DEFINES_SVH
`define BITMAP_PAGE_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, muted while reset is low.
`define BPA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, muted while reset is low.
`define BPA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/bpa_pkg.sv -----
package bpa_pkg;

    // Bitmap geometry.
    localparam int WORD_BITS        = 64;
    localparam int BITMAP_WORDS_DEF = 64;

    // Request opcodes.
    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_FREE    = 2'd1;
    localparam logic [1:0] OP_RESERVE = 2'd2;

    // Response status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_BAD   = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;
        logic       scan_init;
        logic       rng_req;
        logic       rng_alloc;
        logic       rd;
        logic       scan;
        logic       wr_clr;
        logic       wr_rng;
        logic       addr_inc;
        logic       out_load;
        logic [1:0] out_st;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_alloc;
        logic bad;
        logic too_big;
        logic zero_count;
        logic hit_now;
        logic chunk_last;
        logic addr_last;
        logic range_last;
        logic out_busy;
    } t_stat;

endpackage

// ----- hw/rtl/bpa_if.sv -----
// Request channel.
interface bpa_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [11:0] base_page;
    logic [12:0] page_count;

    modport source (output valid, output opcode, output base_page, output page_count,
                    input ready);
    modport sink (input valid, input opcode, input base_page, input page_count,
                  output ready);
endinterface

// Response channel.
interface bpa_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [11:0] first_page;

    modport source (output valid, output status, output first_page, input ready);
    modport sink (input valid, input status, input first_page, output ready);
endinterface

// ----- hw/rtl/bitmap_page_allocator.sv -----
// Channel   Dir  Fields                                 Word accepted
// i_req     in   opcode, base_page, page_count          valid && ready
// o_rsp     out  status, first_page                     valid && ready
//
// Free and reserve read and then write back each bitmap word touched.
// Allocate scans 8 pages a cycle, reading each word and then scanning it byte by byte,
// then reads and writes each word of the run; the byte-wide scan step sets this rate.
// After reset a clearing pass writes every word as all used.
// One request is in work at a time; a new one is taken while a result waits.
module bitmap_page_allocator
    import bpa_pkg::*;
#(
    parameter int BITMAP_WORDS = BITMAP_WORDS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bpa_req_if.sink   i_req,
    bpa_rsp_if.source o_rsp
);

    t_cmd  cmd;
    t_stat st;
    logic  in_ready;

    bpa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_st       (st),
        .o_cmd      (cmd),
        .o_in_ready (in_ready)
    );

    bpa_dpath #(
        .BITMAP_WORDS (BITMAP_WORDS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_ready (in_ready),
        .o_st       (st),
        .i_req      (i_req),
        .o_rsp      (o_rsp)
    );

endmodule

// ----- hw/rtl/bpa_ctrl.sv -----
module bpa_ctrl
    import bpa_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_stat i_st,
    output t_cmd  o_cmd,
    output logic  o_in_ready
);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DECODE, S_SCAN_RD, S_SCAN_RUN,
        S_ALLOC_SET, S_RW_RD, S_RW_WR, S_RESP
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_res_st, n_res_st;

    assign o_in_ready = (r_state == S_IDLE);

    // Next state and command decode.
    always_comb begin
        n_state  = r_state;
        n_res_st = r_res_st;
        o_cmd    = '0;
        o_cmd.out_st = r_res_st;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.wr_clr   = 1'b1;
                o_cmd.addr_inc = 1'b1;
                if (i_st.addr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_st.bad) begin
                    n_res_st = ST_BAD;
                    n_state  = S_RESP;
                end else if (i_st.is_alloc && i_st.too_big) begin
                    n_res_st = ST_NOFIT;
                    n_state  = S_RESP;
                end else if (i_st.is_alloc) begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = S_SCAN_RD;
                end else if (i_st.zero_count) begin
                    n_res_st = ST_OK;
                    n_state  = S_RESP;
                end else begin
                    o_cmd.rng_req = 1'b1;
                    n_state       = S_RW_RD;
                end
            end
            S_SCAN_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_SCAN_RUN;
            end
            S_SCAN_RUN: begin
                o_cmd.scan = 1'b1;
                if (i_st.hit_now) begin
                    n_state = S_ALLOC_SET;
                end else if (i_st.chunk_last) begin
                    if (i_st.addr_last) begin
                        n_res_st = ST_NOFIT;
                        n_state  = S_RESP;
                    end else begin
                        o_cmd.addr_inc = 1'b1;
                        n_state        = S_SCAN_RD;
                    end
                end
            end
            S_ALLOC_SET: begin
                o_cmd.rng_alloc = 1'b1;
                n_state         = S_RW_RD;
            end
            S_RW_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_RW_WR;
            end
            S_RW_WR: begin
                o_cmd.wr_rng = 1'b1;
                if (i_st.range_last) begin
                    n_res_st = ST_OK;
                    n_state  = S_RESP;
                end else begin
                    o_cmd.addr_inc = 1'b1;
                    n_state        = S_RW_RD;
                end
            end
            S_RESP: begin
                if (!i_st.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State and registered result code.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_res_st <= ST_OK;
        end else begin
            r_state  <= n_state;
            r_res_st <= n_res_st;
        end
    end

endmodule

// ----- hw/rtl/bpa_dpath.sv -----
`include "bitmap_page_allocator_defines.svh"
module bpa_dpath
    import bpa_pkg::*;
#(
    parameter int BITMAP_WORDS = BITMAP_WORDS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    input  logic             i_in_ready,
    output t_stat            o_st,
    bpa_req_if.sink          i_req,
    bpa_rsp_if.source        o_rsp
);

    localparam int AW = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
    localparam int PW = AW + 6;
    localparam int EW = PW + 1;
    localparam logic [31:0] TOTAL_32 = 32'(BITMAP_WORDS * WORD_BITS);
    localparam logic [AW-1:0] LAST_WORD = AW'(BITMAP_WORDS - 1);

    logic [WORD_BITS-1:0] mem [BITMAP_WORDS];

    logic [1:0]           r_op;
    logic [11:0]          r_start;
    logic [12:0]          r_count;
    logic [AW-1:0]        r_addr;
    logic [WORD_BITS-1:0] r_rdata;
    logic [2:0]           r_chunk;
    logic [12:0]          r_run;
    logic [PW-1:0]        r_endp;
    logic [PW-1:0]        r_lo;
    logic [EW-1:0]        r_hi;
    logic                 r_o_valid;
    logic [1:0]           r_o_status;
    logic [11:0]          r_o_page;

    logic                 is_alloc, is_rng;
    logic [31:0]          start32, sum32, hi32, alloc_lo32, lo_ext32;
    logic [EW-1:0]        hm1;
    logic [AW-1:0]        lo_word, hi_word;
    logic [WORD_BITS-1:0] mask, wdata;
    logic [12:0]          run_n;
    logic                 hit;
    logic [2:0]           hpos;

    // Request decode.
    assign is_alloc   = (r_op == OP_ALLOC);
    assign is_rng     = (r_op == OP_FREE) || (r_op == OP_RESERVE);
    assign start32    = {20'b0, r_start};
    assign sum32      = start32 + {19'b0, r_count};
    assign hi32       = (sum32 > TOTAL_32) ? TOTAL_32 : sum32;
    assign alloc_lo32 = 32'(r_endp) + 32'd1 - {19'b0, r_count};
    assign lo_ext32   = 32'(r_lo);

    // Word bounds of the range being written.
    assign hm1     = r_hi - EW'(1);
    assign lo_word = r_lo[PW-1:6];
    assign hi_word = hm1[PW-1:6];

    // Bits of the current word that fall inside the range.
    always_comb begin
        for (int b = 0; b < WORD_BITS; b++) begin
            mask[b] = ((r_addr != lo_word) || (6'(b) >= r_lo[5:0]))
                   && ((r_addr != hi_word) || (6'(b) <= hm1[5:0]));
        end
    end

    assign wdata = i_cmd.wr_clr ? '1
                 : ((r_op == OP_FREE) ? (r_rdata & ~mask) : (r_rdata | mask));

    // First-fit run counter over one byte of the current word.
    always_comb begin
        run_n = r_run;
        hit   = 1'b0;
        hpos  = '0;
        for (int i = 0; i < 8; i++) begin
            if (!hit) begin
                if (r_rdata[{r_chunk, 3'(i)}]) begin
                    run_n = '0;
                end else begin
                    run_n = run_n + 13'd1;
                    if (run_n == r_count) begin
                        hit  = 1'b1;
                        hpos = 3'(i);
                    end
                end
            end
        end
    end

    // Status to the controller.
    always_comb begin
        o_st.is_alloc   = is_alloc;
        o_st.bad        = (is_alloc && (r_count == '0))
                       || (is_rng && (start32 >= TOTAL_32))
                       || (!is_alloc && !is_rng);
        o_st.too_big    = ({19'b0, r_count} > TOTAL_32);
        o_st.zero_count = (r_count == '0);
        o_st.hit_now    = hit;
        o_st.chunk_last = (r_chunk == 3'd7);
        o_st.addr_last  = (r_addr == LAST_WORD);
        o_st.range_last = (r_addr == hi_word);
        o_st.out_busy   = r_o_valid && !o_rsp.ready;
    end

    // Bitmap memory with registered read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_clr || i_cmd.wr_rng) begin
            mem[r_addr] <= wdata;
        end
        if (i_cmd.rd) begin
            r_rdata <= mem[r_addr];
        end
    end

    // Request, scan and range registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
        end else if (i_cmd.scan_init) begin
            r_addr <= '0;
        end else if (i_cmd.rng_req) begin
            r_addr <= start32[PW-1:6];
        end else if (i_cmd.rng_alloc) begin
            r_addr <= alloc_lo32[PW-1:6];
        end else if (i_cmd.addr_inc) begin
            r_addr <= (r_addr == LAST_WORD) ? '0 : r_addr + AW'(1);
        end
        if (i_cmd.load) begin
            r_op    <= i_req.opcode;
            r_start <= i_req.base_page;
            r_count <= i_req.page_count;
        end
        if (i_cmd.scan_init) begin
            r_run   <= '0;
            r_chunk <= '0;
        end else if (i_cmd.scan) begin
            r_run   <= run_n;
            r_chunk <= r_chunk + 3'd1;
            if (hit) r_endp <= {r_addr, r_chunk, hpos};
        end
        if (i_cmd.rng_req) begin
            r_lo <= start32[PW-1:0];
            r_hi <= hi32[EW-1:0];
        end else if (i_cmd.rng_alloc) begin
            r_lo <= alloc_lo32[PW-1:0];
            r_hi <= {1'b0, r_endp} + EW'(1);
        end
    end

    // Output word register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_o_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_o_valid <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_o_status <= i_cmd.out_st;
            r_o_page   <= ((i_cmd.out_st == ST_OK) && is_alloc) ? lo_ext32[11:0] : '0;
        end
    end

    assign i_req.ready      = i_in_ready;
    assign o_rsp.valid      = r_o_valid;
    assign o_rsp.status     = r_o_status;
    assign o_rsp.first_page = r_o_page;

    `BPA_ASSERT_IMP(a_mask_nonempty, i_cmd.wr_rng, (|mask), "range write with empty mask")
    `BPA_ASSERT_IMP(a_no_overwrite, i_cmd.out_load, !(r_o_valid && !o_rsp.ready),
        "result overwritten before taken")
    `BPA_ASSERT_IMP(a_page_zero, r_o_valid && (r_o_status != ST_OK), (r_o_page == '0),
        "page number set on failed request")
    `BPA_ASSERT_NXT(a_load_decodes, i_cmd.load, !i_cmd.rd && !i_cmd.wr_rng,
        "memory access right after request load")

endmodule
